// ----- hw/rtl/lqrg_pkg.sv -----
// Package for the LQR gain solve and control unit.
// Holds register codes, reset values, rounding-shift codes and saturating helpers.
// No dependencies.
package lqrg_pkg;

    localparam int MAX_ITER_DEF = 500;
    localparam int TOL_DEF      = 1;
    localparam int FRAC_DEF     = 24;

    localparam int ADDR_W = 5;

    typedef logic signed [63:0] t_q32;

    localparam t_q32 SAT64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SAT65  = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] NSAT65 = -65'sh0_7FFF_FFFF_FFFF_FFFF;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_GOAL  = 3'd0,
        REG_POLE  = 3'd1,
        REG_BGAIN = 3'd2,
        REG_TS    = 3'd3,
        REG_QZ    = 3'd4,
        REG_QV    = 3'd5,
        REG_R     = 3'd6,
        REG_VLIM  = 3'd7
    } t_reg_idx;

    localparam logic [31:0] RST_GOAL  = 32'd50331648;
    localparam logic [26:0] RST_POLE  = 27'd16581527;
    localparam logic [25:0] RST_BGAIN = 26'd218188;
    localparam logic [24:0] RST_TS    = 25'd335544;
    localparam logic [30:0] RST_QZ    = 31'd83886080;
    localparam logic [30:0] RST_QV    = 31'd16777216;
    localparam logic [30:0] RST_R     = 31'd5033165;
    localparam logic [28:0] RST_VLIM  = 29'd33554432;

    // Rounding shift applied after a product.
    typedef enum logic [1:0] {
        SH_FRAC,
        SH_32,
        SH_GAIN
    } t_shift;

    function automatic t_q32 sat_add(input t_q32 a, input t_q32 b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > SAT65) begin
            return SAT64;
        end else if (s < NSAT65) begin
            return -SAT64;
        end
        return s[63:0];
    endfunction

    function automatic t_q32 sat_sub(input t_q32 a, input t_q32 b);
        t_q32 bc;
        bc = (b < -SAT64) ? -SAT64 : b;
        return sat_add(a, -bc);
    endfunction

    function automatic logic [63:0] mag(input t_q32 x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    function automatic t_q32 clamp(input t_q32 v, input t_q32 lim);
        if (v > lim) begin
            return lim;
        end else if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/lqr_gain_solve_and_control_unit.sv -----
// Top level of the LQR gain solve and control unit.
// Depends on lqrg_pkg (types, register codes, saturating helpers).
//
// Vertical-axis LQR regulator for a position/velocity model. A transfer with
// mode 0 solves the discrete Riccati iteration from the configured weights and
// stores new gains; a transfer with mode 1 turns a measured height and climb
// rate into a clamped velocity command from the stored gains. Every input
// transfer yields exactly one output transfer carrying the command (zero for a
// solve), both gains, the iteration count and the converged flag of the last
// solve. Items are taken one at a time: o_ready is high only when idle. All
// arithmetic runs on one shared 64x64 multiplier, built from a single 32x32
// multiplier used four times per product between issue and rounding, and one
// restoring divider that produces one quotient bit a cycle. A control item
// takes two products (gain times height error, gain times climb rate), then
// sums and clamps them and holds the result until the result side takes it.
// Each Riccati iteration of a solve takes six products and two quotients for
// the gain terms and seven products for the update, then advances P; a solve
// runs up to MAX_ITERATIONS iterations, plus a final gain pass. The user must
// write configuration over the APB port only while the unit is idle; the unit
// does not enforce this. pready is always high.
module lqr_gain_solve_and_control_unit #(
    parameter int MAX_ITERATIONS = lqrg_pkg::MAX_ITER_DEF,
    parameter int TOLERANCE_LSB  = lqrg_pkg::TOL_DEF,
    parameter int FRAC_BITS      = lqrg_pkg::FRAC_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lqrg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_mode,
    input  logic signed [31:0]          i_height_meas,
    input  logic signed [31:0]          i_climb_meas,
    // output channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [29:0]          o_velocity_cmd,
    output logic signed [31:0]          o_gain_pos,
    output logic signed [31:0]          o_gain_vel,
    output logic [8:0]                  o_iter_count,
    output logic                        o_converged
);
    import lqrg_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITERATIONS + 1);
    localparam int QSH   = 32 - FRAC_BITS;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GT0, ST_GT1, ST_GT2, ST_GT3, ST_GT4, ST_GT5, ST_GT6, ST_GT7, ST_GT8,
        ST_IT1, ST_IT2, ST_IT3, ST_IT4, ST_IT5, ST_IT6, ST_IT7, ST_IT8,
        ST_FN1, ST_FN2,
        ST_SM0, ST_SM1, ST_SM2,
        ST_MUL, ST_MFIN, ST_DIV, ST_DFIN,
        ST_OUT
    } t_state;

    // Configuration registers
    logic signed [31:0] r_goal;
    logic signed [26:0] r_pole;
    logic signed [25:0] r_bgain;
    logic [24:0]        r_ts;
    logic [30:0]        r_qz;
    logic [30:0]        r_qv;
    logic [30:0]        r_r;
    logic [28:0]        r_vlim;

    // Sequencer and working values
    t_state             r_state;
    t_state             r_ret;
    t_q32               r_p11, r_p12, r_p22;
    t_q32               r_n11, r_n12, r_n22;
    t_q32               r_t, r_m22, r_m12, r_pb1, r_pb2, r_s, r_q1, r_q2, r_res;
    logic signed [31:0] r_gp, r_gv;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_conv;
    logic               r_final;
    logic [8:0]         r_last_cnt;
    logic               r_last_conv;
    logic [29:0]        r_cmd;
    logic signed [32:0] r_ez;
    logic signed [31:0] r_v;

    // Shared multiplier
    logic [63:0]        r_ma, r_mb;
    logic               r_mneg;
    t_shift             r_msh;
    logic [127:0]       r_acc;
    logic [1:0]         r_k;

    // Shared divider
    logic [95:0]        r_dq;
    logic [63:0]        r_rem;
    logic [63:0]        r_den;
    logic               r_dneg;
    logic [6:0]         r_dk;

    // Extended operands
    t_q32 a64, b64, ts64, qz64, qv64, rq64, one64;
    assign a64   = {{37{r_pole[26]}}, r_pole};
    assign b64   = {{38{r_bgain[25]}}, r_bgain};
    assign ts64  = {39'd0, r_ts};
    assign qz64  = t_q32'({33'd0, r_qz}) <<< QSH;
    assign qv64  = t_q32'({33'd0, r_qv}) <<< QSH;
    assign rq64  = t_q32'({33'd0, r_r}) <<< QSH;
    assign one64 = 64'sd1;

    // Multiplier datapath: one 32x32 partial product a cycle
    logic [31:0]  mx, my;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic         movf;
    logic [63:0]  mrs;
    t_q32         mmag, mul_out;

    always_comb begin
        mx = r_k[1] ? r_ma[63:32] : r_ma[31:0];
        my = r_k[0] ? r_mb[63:32] : r_mb[31:0];
        pp = mx * my;
        case (r_k)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        case (r_msh)
            SH_FRAC: begin
                movf = |r_acc[127:64+FRAC_BITS];
                mrs  = r_acc[FRAC_BITS +: 64];
            end
            SH_GAIN: begin
                movf = |r_acc[127:64+QSH];
                mrs  = r_acc[QSH +: 64];
            end
            default: begin
                movf = |r_acc[127:96];
                mrs  = r_acc[95:32];
            end
        endcase
        mmag    = (movf || mrs[63]) ? SAT64 : t_q32'(mrs);
        mul_out = r_mneg ? -mmag : mmag;
    end

    // Divider datapath: one quotient bit a cycle
    logic [63:0] rem_sh;
    logic        dge;
    logic        dovf;
    logic        drnd;
    logic [63:0] dqs;
    t_q32        dmag, div_out;

    always_comb begin
        rem_sh  = {r_rem[62:0], r_dq[95]};
        dge     = rem_sh >= r_den;
        dovf    = |r_dq[95:63];
        drnd    = {r_rem[62:0], 1'b0} >= r_den;
        dqs     = {1'b0, r_dq[62:0]} + {63'd0, drnd};
        dmag    = (dovf || dqs[63]) ? SAT64 : t_q32'(dqs);
        div_out = r_dneg ? -dmag : dmag;
    end

    // Sequencer: pick the next operation and the state to return to
    logic   op_go, op_div;
    t_q32   op_x, op_y;
    t_shift op_sh;
    t_state op_ret;
    t_q32   sum_tr, s_raw, s_val, n11_val, n12_val, n22_val, cmd_full;
    logic [63:0]      dsum;
    logic [CNT_W-1:0] cnt_inc;

    always_comb begin
        sum_tr   = sat_add(r_t, r_res);
        s_raw    = sat_add(rq64, r_res);
        s_val    = (s_raw < one64) ? one64 : s_raw;
        n11_val  = sat_add(sat_sub(r_p11, r_res), qz64);
        n12_val  = sat_sub(r_m12, r_res);
        n22_val  = sat_add(sat_sub(r_t, r_res), qv64);
        dsum     = mag(sat_sub(r_n11, r_p11)) + mag(sat_sub(r_n12, r_p12))
                 + mag(sat_sub(r_n22, r_p22));
        cnt_inc  = r_cnt + 1'b1;
        cmd_full = -clamp(sum_tr, {35'd0, r_vlim});

        op_go  = 1'b0;
        op_div = 1'b0;
        op_x   = r_p12;
        op_y   = ts64;
        op_sh  = SH_FRAC;
        op_ret = ST_IDLE;
        case (r_state)
            ST_GT0: begin
                op_go = 1'b1; op_x = r_p12; op_y = ts64; op_ret = ST_GT1;
            end
            ST_GT1: begin
                op_go = 1'b1; op_x = r_p22; op_y = a64; op_ret = ST_GT2;
            end
            ST_GT2: begin
                op_go = 1'b1; op_x = r_p12; op_y = b64; op_ret = ST_GT3;
            end
            ST_GT3: begin
                op_go = 1'b1; op_x = r_m22; op_y = b64; op_ret = ST_GT4;
            end
            ST_GT4: begin
                op_go = 1'b1; op_x = r_p22; op_y = b64; op_ret = ST_GT5;
            end
            ST_GT5: begin
                op_go = 1'b1; op_x = r_res; op_y = b64; op_ret = ST_GT6;
            end
            ST_GT6: begin
                op_go = 1'b1; op_div = 1'b1; op_x = r_pb1; op_y = s_val; op_ret = ST_GT7;
            end
            ST_GT7: begin
                op_go = 1'b1; op_div = 1'b1; op_x = r_pb2; op_y = r_s; op_ret = ST_GT8;
            end
            ST_GT8: begin
                op_go = 1'b1;
                if (r_final) begin
                    op_x = r_q1; op_y = one64; op_sh = SH_GAIN; op_ret = ST_FN1;
                end else begin
                    op_x = r_p11; op_y = ts64; op_ret = ST_IT1;
                end
            end
            ST_IT1: begin
                op_go = 1'b1; op_x = r_p12; op_y = a64; op_ret = ST_IT2;
            end
            ST_IT2: begin
                op_go = 1'b1; op_x = sum_tr; op_y = ts64; op_ret = ST_IT3;
            end
            ST_IT3: begin
                op_go = 1'b1; op_x = r_m22; op_y = a64; op_ret = ST_IT4;
            end
            ST_IT4: begin
                op_go = 1'b1; op_x = r_pb1; op_y = r_q1; op_sh = SH_32; op_ret = ST_IT5;
            end
            ST_IT5: begin
                op_go = 1'b1; op_x = r_pb1; op_y = r_q2; op_sh = SH_32; op_ret = ST_IT6;
            end
            ST_IT6: begin
                op_go = 1'b1; op_x = r_pb2; op_y = r_q2; op_sh = SH_32; op_ret = ST_IT7;
            end
            ST_FN1: begin
                op_go = 1'b1; op_x = r_q2; op_y = one64; op_sh = SH_GAIN; op_ret = ST_FN2;
            end
            ST_SM0: begin
                op_go = 1'b1;
                op_x  = {{32{r_gp[31]}}, r_gp};
                op_y  = {{31{r_ez[32]}}, r_ez};
                op_ret = ST_SM1;
            end
            ST_SM1: begin
                op_go = 1'b1;
                op_x  = {{32{r_gv[31]}}, r_gv};
                op_y  = {{32{r_v[31]}}, r_v};
                op_ret = ST_SM2;
            end
            default: begin
                op_go = 1'b0;
            end
        endcase
    end

    // Clamp a gain into the signed 32-bit range.
    function automatic logic signed [31:0] gain32(input t_q32 v);
        t_q32 c;
        c = clamp(v, 64'sh0000_0000_7FFF_FFFF);
        return c[31:0];
    endfunction

    // Rounding constant preloaded into the product accumulator.
    function automatic logic [127:0] round_init(input t_shift sh);
        case (sh)
            SH_FRAC: return 128'd1 << (FRAC_BITS - 1);
            SH_GAIN: return 128'd1 << (QSH - 1);
            default: return 128'd1 << 31;
        endcase
    endfunction

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_IDLE;
            r_goal      <= RST_GOAL;
            r_pole      <= RST_POLE;
            r_bgain     <= RST_BGAIN;
            r_ts        <= RST_TS;
            r_qz        <= RST_QZ;
            r_qv        <= RST_QV;
            r_r         <= RST_R;
            r_vlim      <= RST_VLIM;
            r_gp        <= '0;
            r_gv        <= '0;
            r_p11       <= '0;
            r_p12       <= '0;
            r_p22       <= '0;
            r_last_cnt  <= '0;
            r_last_conv <= 1'b0;
            r_cmd       <= '0;
            r_cnt       <= '0;
            r_conv      <= 1'b0;
            r_final     <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_wr) begin
                unique case (t_reg_idx'(paddr[4:2]))
                    REG_GOAL:  r_goal  <= pwdata;
                    REG_POLE:  r_pole  <= pwdata[26:0];
                    REG_BGAIN: r_bgain <= pwdata[25:0];
                    REG_TS:    r_ts    <= pwdata[24:0];
                    REG_QZ:    r_qz    <= pwdata[30:0];
                    REG_QV:    r_qv    <= pwdata[30:0];
                    REG_R:     r_r     <= pwdata[30:0];
                    REG_VLIM:  r_vlim  <= pwdata[28:0];
                endcase
            end

            // launch a product or a quotient, then come back to r_ret
            if (op_go) begin
                r_ret <= op_ret;
                if (op_div) begin
                    r_dq    <= {mag(op_x), 32'd0};
                    r_rem   <= '0;
                    r_den   <= 64'(op_y);
                    r_dneg  <= op_x[63];
                    r_dk    <= '0;
                    r_state <= ST_DIV;
                end else begin
                    r_ma    <= mag(op_x);
                    r_mb    <= mag(op_y);
                    r_mneg  <= op_x[63] ^ op_y[63];
                    r_msh   <= op_sh;
                    r_acc   <= round_init(op_sh);
                    r_k     <= '0;
                    r_state <= ST_MUL;
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        if (i_mode) begin
                            r_ez    <= {i_height_meas[31], i_height_meas}
                                     - {r_goal[31], r_goal};
                            r_v     <= i_climb_meas;
                            r_state <= ST_SM0;
                        end else begin
                            // start from P = diag(q_z, q_v)
                            r_p11   <= qz64;
                            r_p12   <= '0;
                            r_p22   <= qv64;
                            r_cnt   <= '0;
                            r_conv  <= 1'b0;
                            r_final <= 1'b0;
                            r_state <= ST_GT0;
                        end
                    end
                end
                ST_GT1: r_t   <= r_res;
                ST_GT2: r_m22 <= sum_tr;
                ST_GT3: r_pb1 <= r_res;
                ST_GT4: r_pb2 <= r_res;
                ST_GT6: r_s   <= s_val;
                ST_GT7: r_q1  <= r_res;
                ST_GT8: r_q2  <= r_res;
                ST_IT1: r_t   <= r_res;
                ST_IT2: r_m12 <= sum_tr;
                ST_IT3: r_t   <= r_res;
                ST_IT4: r_t   <= sum_tr;
                ST_IT5: r_n11 <= n11_val;
                ST_IT6: r_n12 <= n12_val;
                ST_IT7: begin
                    r_n22   <= n22_val;
                    r_state <= ST_IT8;
                end
                ST_IT8: begin
                    // advance P, stop on tolerance or at the iteration cap
                    r_p11   <= r_n11;
                    r_p12   <= r_n12;
                    r_p22   <= r_n22;
                    r_cnt   <= cnt_inc;
                    r_state <= ST_GT0;
                    if (dsum < 64'(TOLERANCE_LSB)) begin
                        r_conv  <= 1'b1;
                        r_final <= 1'b1;
                    end else if (cnt_inc == CNT_W'(MAX_ITERATIONS)) begin
                        r_final <= 1'b1;
                    end
                end
                ST_FN1: r_gp <= gain32(r_res);
                ST_FN2: begin
                    r_gv        <= gain32(r_res);
                    r_last_cnt  <= (32'(r_cnt) > 32'd511) ? 9'd511 : 9'(r_cnt);
                    r_last_conv <= r_conv;
                    r_cmd       <= '0;
                    r_state     <= ST_OUT;
                end
                ST_SM1: r_t <= r_res;
                ST_SM2: begin
                    r_cmd   <= cmd_full[29:0];
                    r_state <= ST_OUT;
                end
                ST_MUL: begin
                    r_acc <= r_acc + pp_sh;
                    r_k   <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= ST_MFIN;
                    end
                end
                ST_MFIN: begin
                    r_res   <= mul_out;
                    r_state <= r_ret;
                end
                ST_DIV: begin
                    r_rem <= dge ? (rem_sh - r_den) : rem_sh;
                    r_dq  <= {r_dq[94:0], dge};
                    r_dk  <= r_dk + 7'd1;
                    if (r_dk == 7'd95) begin
                        r_state <= ST_DFIN;
                    end
                end
                ST_DFIN: begin
                    r_res   <= div_out;
                    r_state <= r_ret;
                end
                ST_OUT: begin
                    // hold the result until the transfer completes
                    if (i_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    // issue-only states: the launch above sets the next state
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_GOAL:  prdata = r_goal;
            REG_POLE:  prdata = {5'd0, r_pole};
            REG_BGAIN: prdata = {6'd0, r_bgain};
            REG_TS:    prdata = {7'd0, r_ts};
            REG_QZ:    prdata = {1'd0, r_qz};
            REG_QV:    prdata = {1'd0, r_qv};
            REG_R:     prdata = {1'd0, r_r};
            REG_VLIM:  prdata = {3'd0, r_vlim};
        endcase
    end

    assign pready         = 1'b1;
    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = (r_state == ST_OUT);
    assign o_velocity_cmd = r_cmd;
    assign o_gain_pos     = r_gp;
    assign o_gain_vel     = r_gv;
    assign o_iter_count   = r_last_cnt;
    assign o_converged    = r_last_conv;

endmodule

// ----- dv/lqr_gain_checker.sv -----
// Checker for the LQR gain solve and control unit: tracks the configuration
// writes, predicts every result and compares it with what the unit delivers.
// Depends on lqrg_pkg (register indexes, reset values, Q32.32 type).
module lqr_gain_checker
    import lqrg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               in_mode,
    input  logic [31:0]        in_height,
    input  logic [31:0]        in_climb,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [29:0]        out_cmd,
    input  logic [31:0]        out_gain_pos,
    input  logic [31:0]        out_gain_vel,
    input  logic [8:0]         out_iters,
    input  logic               out_conv,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_ITER = 500;
    localparam int          TOL      = 1;
    localparam int          FB       = 24;
    localparam logic [63:0] SAT      = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [29:0] cmd;
        logic [31:0] gain_pos;
        logic [31:0] gain_vel;
        logic [8:0]  iters;
        logic        conv;
    } t_result;

    t_result     result_q[$];
    logic [31:0] cfg[8];
    t_q32        kz, kv, p11_s, p12_s, p22_s;
    logic [8:0]  iters_s;
    logic        conv_s;
    int          fails;

    function automatic logic [63:0] abs_val(input t_q32 x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    function automatic t_q32 add_sat(input t_q32 a, input t_q32 b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > $signed({1'b0, SAT})) return SAT;
        if (s < -$signed({1'b0, SAT})) return -SAT;
        return s[63:0];
    endfunction

    function automatic t_q32 sub_sat(input t_q32 a, input t_q32 b);
        t_q32 bc;
        bc = (b < -$signed(SAT)) ? -$signed(SAT) : b;
        return add_sat(a, -bc);
    endfunction

    // round(x*y / 2^sh), ties away from zero, saturated
    function automatic t_q32 round_product(input t_q32 x, input t_q32 y, input int sh);
        logic [127:0] p;
        logic         neg;
        neg = x[63] ^ y[63];
        p = {64'd0, abs_val(x)} * {64'd0, abs_val(y)};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        if (p > {64'd0, SAT}) p = {64'd0, SAT};
        return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
    endfunction

    // round(num * 2^32 / den), den >= 1
    function automatic t_q32 divide_q32(input t_q32 num, input t_q32 den);
        logic [127:0] n, q, r;
        logic [63:0]  un;
        un = abs_val(num);
        if (un / den > 64'h7FFF_FFFF) begin
            q = {64'd0, SAT};
        end else begin
            n = {32'd0, un, 32'd0};
            q = n / {64'd0, den};
            r = n % {64'd0, den};
            if ((r << 1) >= {64'd0, den}) q = q + 1;
            if (q > {64'd0, SAT}) q = {64'd0, SAT};
        end
        return num[63] ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic t_q32 pole();
        return {{37{cfg[REG_POLE][26]}}, cfg[REG_POLE][26:0]};
    endfunction

    function automatic t_q32 bgain();
        return {{38{cfg[REG_BGAIN][25]}}, cfg[REG_BGAIN][25:0]};
    endfunction

    function automatic void gain_terms(input t_q32 p12, input t_q32 p22,
                                       output t_q32 pb1, output t_q32 pb2,
                                       output t_q32 m22, output t_q32 q1,
                                       output t_q32 q2);
        t_q32 s;
        m22 = add_sat(round_product(p12, t_q32'(cfg[REG_TS]), FB),
                      round_product(p22, pole(), FB));
        pb1 = round_product(p12, bgain(), FB);
        pb2 = round_product(m22, bgain(), FB);
        s = add_sat(t_q32'(cfg[REG_R]) <<< (32 - FB),
                    round_product(round_product(p22, bgain(), FB), bgain(), FB));
        if (s < 1) s = 1;
        q1 = divide_q32(pb1, s);
        q2 = divide_q32(pb2, s);
    endfunction

    function automatic t_q32 clamp_to(input t_q32 v, input t_q32 lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Riccati iteration, then gain extraction; updates the predicted state
    function automatic void solve_gains();
        t_q32        a, ts, qz, qv, p11, p12, p22;
        t_q32        pb1, pb2, m22, q1, q2, m12, apa22, n11, n12, n22;
        logic [63:0] d;
        int          count;
        logic        done;
        a = pole();
        ts = t_q32'(cfg[REG_TS]);
        qz = t_q32'(cfg[REG_QZ]) <<< (32 - FB);
        qv = t_q32'(cfg[REG_QV]) <<< (32 - FB);
        p11 = qz;
        p12 = 0;
        p22 = qv;
        count = 0;
        done = 1'b0;
        while (count < MAX_ITER && !done) begin
            gain_terms(p12, p22, pb1, pb2, m22, q1, q2);
            m12 = add_sat(round_product(p11, ts, FB), round_product(p12, a, FB));
            apa22 = add_sat(round_product(m12, ts, FB), round_product(m22, a, FB));
            n11 = add_sat(sub_sat(p11, round_product(pb1, q1, 32)), qz);
            n12 = sub_sat(m12, round_product(pb1, q2, 32));
            n22 = add_sat(sub_sat(apa22, round_product(pb2, q2, 32)), qv);
            // the sum wraps at 64 bits
            d = abs_val(sub_sat(n11, p11)) + abs_val(sub_sat(n12, p12))
                + abs_val(sub_sat(n22, p22));
            p11 = n11;
            p12 = n12;
            p22 = n22;
            count++;
            if (d < TOL) done = 1'b1;
        end
        gain_terms(p12, p22, pb1, pb2, m22, q1, q2);
        kz = clamp_to(round_product(q1, 1, 32 - FB), 64'sh7FFF_FFFF);
        kv = clamp_to(round_product(q2, 1, 32 - FB), 64'sh7FFF_FFFF);
        p11_s = p11;
        p12_s = p12;
        p22_s = p22;
        iters_s = (count > 511) ? 9'd511 : 9'(count);
        conv_s = done;
    endfunction

    function automatic t_result predict(input logic mode, input logic [31:0] h,
                                        input logic [31:0] c);
        t_result res;
        t_q32    ez, sum, cmd;
        cmd = 0;
        if (!mode) begin
            solve_gains();
        end else begin
            ez = t_q32'($signed(h)) - t_q32'($signed(cfg[REG_GOAL]));
            sum = add_sat(round_product(kz, ez, FB),
                          round_product(kv, t_q32'($signed(c)), FB));
            cmd = -clamp_to(sum, t_q32'(cfg[REG_VLIM]));
        end
        res.cmd = cmd[29:0];
        res.gain_pos = kz[31:0];
        res.gain_vel = kv[31:0];
        res.iters = iters_s;
        res.conv = conv_s;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result      want;
        t_result      got;
        logic [31:0]  wmask;
        if (!i_rst_n) begin
            cfg[REG_GOAL]  = 32'(RST_GOAL);
            cfg[REG_POLE]  = 32'(RST_POLE);
            cfg[REG_BGAIN] = 32'(RST_BGAIN);
            cfg[REG_TS]    = 32'(RST_TS);
            cfg[REG_QZ]    = 32'(RST_QZ);
            cfg[REG_QV]    = 32'(RST_QV);
            cfg[REG_R]     = 32'(RST_R);
            cfg[REG_VLIM]  = 32'(RST_VLIM);
            kz = 0;
            kv = 0;
            p11_s = 0;
            p12_s = 0;
            p22_s = 0;
            iters_s = 0;
            conv_s = 0;
            result_q.delete();
            fails = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_POLE:  wmask = 32'h07FF_FFFF;
                    REG_BGAIN: wmask = 32'h03FF_FFFF;
                    REG_TS:    wmask = 32'h01FF_FFFF;
                    REG_QZ, REG_QV, REG_R: wmask = 32'h7FFF_FFFF;
                    REG_VLIM:  wmask = 32'h1FFF_FFFF;
                    default:   wmask = 32'hFFFF_FFFF;
                endcase
                cfg[paddr[4:2]] = pwdata & wmask;
            end
            if (out_valid && out_ready) begin
                got = {out_cmd, out_gain_pos, out_gain_vel, out_iters, out_conv};
                if (result_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%t: unexpected result transfer %h", $realtime, got);
                end else begin
                    want = result_q.pop_front();
                    if (want.cmd != got.cmd || want.gain_pos != got.gain_pos
                        || want.gain_vel != got.gain_vel || want.iters != got.iters
                        || want.conv != got.conv) begin
                        fails++;
                        if (fails <= 10)
                            $display("%t: mismatch cmd %h/%h kz %h/%h kv %h/%h it %0d/%0d cv %b/%b",
                                     $realtime, want.cmd, got.cmd, want.gain_pos,
                                     got.gain_pos, want.gain_vel, got.gain_vel,
                                     want.iters, got.iters, want.conv, got.conv);
                    end
                end
            end
            if (in_valid && in_ready)
                result_q.push_back(predict(in_mode, in_height, in_climb));
        end
        pending <= result_q.size();
        fail_count <= fails;
    end

endmodule

// ----- dv/tb_lqr_gain_solve_and_control_unit.sv -----
// Testbench top for the LQR gain solve and control unit: clock, reset,
// configuration writes, item stimulus with bursts and stalls, and the verdict.
// Depends on lqrg_pkg, the unit itself and lqr_gain_checker.
module tb_lqr_gain_solve_and_control_unit;
    import lqrg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_mode = 1'b1;
    logic signed [31:0] i_height_meas = '0;
    logic signed [31:0] i_climb_meas = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [29:0] o_velocity_cmd;
    logic signed [31:0] o_gain_pos;
    logic signed [31:0] o_gain_vel;
    logic [8:0]         o_iter_count;
    logic               o_converged;

    int          fail_count;
    int          pending;
    int          burst_left = 0;
    int          stall_phase_cnt = 0;
    logic [31:0] goal_now = 32'(RST_GOAL);

    always #6 i_clk = ~i_clk;

    lqr_gain_solve_and_control_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_height_meas  (i_height_meas),
        .i_climb_meas   (i_climb_meas),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_velocity_cmd (o_velocity_cmd),
        .o_gain_pos     (o_gain_pos),
        .o_gain_vel     (o_gain_vel),
        .o_iter_count   (o_iter_count),
        .o_converged    (o_converged)
    );

    lqr_gain_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .in_valid     (i_valid),
        .in_ready     (o_ready),
        .in_mode      (i_mode),
        .in_height    (i_height_meas),
        .in_climb     (i_climb_meas),
        .out_valid    (o_valid),
        .out_ready    (i_ready),
        .out_cmd      (o_velocity_cmd),
        .out_gain_pos (o_gain_pos),
        .out_gain_vel (o_gain_vel),
        .out_iters    (o_iter_count),
        .out_conv     (o_converged),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Result side: rotate between always ready, coin-flip and mostly stalled,
    // so stalls land on every part of the unit's work.
    always @(negedge i_clk) begin
        stall_phase_cnt <= stall_phase_cnt + 1;
        case ((stall_phase_cnt / 300) % 3)
            0:       i_ready <= 1'b1;
            1:       i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Present one item and hold it until the transfer; then either keep
    // valid high for the next one in the burst or drop it for a random gap.
    task automatic send_item(input logic mode, input logic [31:0] h, input logic [31:0] c);
        int gap;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_mode = mode;
        i_height_meas = h;
        i_climb_meas = c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(0, 12);
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and wait until every outstanding result has been taken.
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Single APB write: setup cycle, then access cycle.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx == REG_GOAL) goal_now = value;
    endtask

    // Write the whole register set; only called with the unit idle.
    task automatic write_all(input logic [31:0] goal, input logic [31:0] a,
                             input logic [31:0] b, input logic [31:0] ts,
                             input logic [31:0] qz, input logic [31:0] qv,
                             input logic [31:0] r, input logic [31:0] vlim);
        drain();
        repeat (20) @(negedge i_clk);
        write_reg(REG_GOAL, goal);
        write_reg(REG_POLE, a);
        write_reg(REG_BGAIN, b);
        write_reg(REG_TS, ts);
        write_reg(REG_QZ, qz);
        write_reg(REG_QV, qv);
        write_reg(REG_R, r);
        write_reg(REG_VLIM, vlim);
    endtask

    // Hit the extremes of both measurements plus a zero sample.
    task automatic extreme_samples();
        send_item(1'b1, 32'h8000_0000, 32'h8000_0000);
        send_item(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(1'b1, 32'h0000_0000, 32'h0000_0000);
    endtask

    initial begin
        logic [31:0] h, c;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Samples before any solve: gains still zero, command zero.
        send_item(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(1'b1, 32'h0000_0000, 32'h0000_0000);

        // Solve with the reset configuration, then regulate around the goal.
        send_item(1'b0, $urandom(), $urandom());
        extreme_samples();
        send_item(1'b1, goal_now + 32'h0010_0000, 32'hFFF0_0000);
        send_item(1'b1, goal_now - 32'h0008_0000, 32'h0020_0000);

        // All weights zero: P stays zero, converges at once; effort zero
        // forces the nonpositive-S floor. Overwide values test masking.
        write_all(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h01FF_FFFF,
                  32'h0, 32'h0, 32'h0, 32'h1FFF_FFFF);
        send_item(1'b0, 32'h0, 32'h0);
        extreme_samples();

        // Opposite extremes, zero effort with nonzero weights, zero limit.
        write_all(32'h8000_0000, 32'h0400_0000, 32'h0200_0000, 32'h1,
                  32'd1677721600, 32'h1, 32'h0, 32'h0);
        send_item(1'b0, 32'h0, 32'h0);
        send_item(1'b1, 32'h1234_5678, 32'h8765_4321);
        send_item(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);

        // Random phases: two with plausible plant models, two with raw bits.
        for (int ph = 0; ph < 4; ph++) begin
            if (ph < 2)
                write_all($urandom(), 32'd16777216 - $urandom_range(0, 1 << 21),
                          ($urandom_range(0, 1) ? 32'd1 : -32'd1) * $urandom_range(1 << 16, 1 << 22),
                          $urandom_range(1 << 14, 1 << 20), $urandom_range(1 << 20, 1 << 28),
                          $urandom_range(1 << 20, 1 << 28), $urandom_range(1 << 20, 1 << 26),
                          $urandom_range(1 << 22, 1 << 28));
            else
                write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom());
            send_item(1'b0, $urandom(), $urandom());
            for (int n = 0; n < 230; n++) begin
                // Hold off once per phase until the unit has caught up.
                if (n == 100) drain();
                if ($urandom_range(0, 2) == 0) begin
                    h = $urandom();
                    c = $urandom();
                end else begin
                    h = goal_now + 32'($signed($urandom_range(0, 1 << 27)) - (1 << 26));
                    c = 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
                end
                send_item(1'b1, h, c);
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // A solve can run up to MAX_ITERATIONS Riccati iterations; a handful of solves
    // plus the samples fit well inside this timeout.
    initial begin
        #480_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- lqr_gain_solve_and_control_unit.f -----
hw/rtl/lqrg_pkg.sv
hw/rtl/lqr_gain_solve_and_control_unit.sv
dv/lqr_gain_checker.sv
dv/tb_lqr_gain_solve_and_control_unit.sv
